// ===== hdl/twr_pkg.sv =====
// Shared types and constants for the timer and watchdog register block.
package twr_pkg;

    localparam int DATA_W = 32;
    localparam int KIND_W = 2;
    localparam int OFFS_W = 5;
    localparam int KEY_W  = 2;
    localparam int CTL_W  = 2;
    localparam int SYS_W  = 4;

    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;

    localparam logic [OFFS_W-1:0] OFFS_CONFIG  = 5'd4;
    localparam logic [OFFS_W-1:0] OFFS_RSTAT   = 5'd5;
    localparam logic [OFFS_W-1:0] OFFS_ISTAT   = 5'd6;
    localparam logic [OFFS_W-1:0] OFFS_IENABLE = 5'd7;
    localparam logic [OFFS_W-1:0] OFFS_CONTROL = 5'd9;
    localparam logic [OFFS_W-1:0] OFFS_COUNTER = 5'd10;
    localparam logic [OFFS_W-1:0] OFFS_LOAD    = 5'd11;
    localparam logic [OFFS_W-1:0] OFFS_PENDING = 5'd13;
    localparam logic [OFFS_W-1:0] OFFS_KEY     = 5'd18;

    localparam logic [DATA_W-1:0] KEY_OFF1 = 32'h0000_aaaa;
    localparam logic [DATA_W-1:0] KEY_OFF2 = 32'h0000_5555;
    localparam logic [DATA_W-1:0] KEY_ON1  = 32'h0000_bbbb;
    localparam logic [DATA_W-1:0] KEY_ON2  = 32'h0000_4444;

    localparam logic [KEY_W-1:0] KEY_NONE     = 2'd0;
    localparam logic [KEY_W-1:0] KEY_OFF_HALF = 2'd1;
    localparam logic [KEY_W-1:0] KEY_ON_HALF  = 2'd2;

    localparam int CFG_NOIDLE_BIT    = 3;
    localparam int CFG_SOFTRESET_BIT = 1;
    localparam int OVF_BIT           = 1;
    localparam int CTL_AR_BIT        = 1;
    localparam int CTL_ST_BIT        = 0;

    localparam logic [SYS_W-1:0]  CFG_STORE_MASK = 4'hd;
    localparam logic [DATA_W-1:0] STAT_RESETDONE = 32'd1;
    localparam logic [DATA_W-1:0] OVF_WORD       = 32'd2;
    localparam logic [DATA_W-1:0] ALL_ONES       = '1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [OFFS_W-1:0] word_offset;
        logic [DATA_W-1:0] write_data;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq;
        logic              watchdog_reset;
    } result_t;

    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctl_t;

endpackage

// ===== hdl/timer_watchdog_registers.sv =====
// Top level of the timer and watchdog register block.
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+-------------------------
//  input    | kind, word_offset, write_data             | in_valid / in_ready
//  result   | read_data, irq, watchdog_reset            | out_valid / out_ready
//  config   | cfg_write_data (watchdog mode)            | cfg_write_en, no wait
//
//  Input register, one pass of decode/increment, result register; one item per clock
//  unless a result stalls. A result leaves the result register when out_ready is high.
//  Reset clears all timer state, the watchdog mode and both pipeline valids.
//  A stalled result holds the input register; a new item enters as soon as it moves.
module timer_watchdog_registers import twr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic              cfg_write_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [KIND_W-1:0] kind,
    input  logic [OFFS_W-1:0] word_offset,
    input  logic [DATA_W-1:0] write_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] read_data,
    output logic              irq,
    output logic              watchdog_reset
);

    logic       mode_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    item_t      in_item;
    item_t      stage_item;
    logic       stage_valid;
    logic       advance;
    stage_ctl_t ctl;
    result_t    result;

    assign in_item = '{kind: kind, word_offset: word_offset, write_data: write_data};
    assign advance = stage_valid && (!out_valid_reg || out_ready);
    assign ctl     = '{valid: stage_valid, advance: advance};

    twr_in_stage u_in_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    twr_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .watchdog_mode (mode_reg),
        .ctl           (ctl),
        .item          (stage_item),
        .result        (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            mode_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= stage_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_data      = out_reg.read_data;
    assign irq            = out_reg.irq;
    assign watchdog_reset = out_reg.watchdog_reset;

endmodule

// ===== hdl/twr_in_stage.sv =====
// Input register stage holding one accepted item.
module twr_in_stage import twr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  item_t      in_item,
    input  logic       advance,
    output logic       stage_valid,
    output item_t      stage_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_valid || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

endmodule

// ===== hdl/twr_core.sv =====
// Timer and watchdog state with its register decode and tick update.
module twr_core import twr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       watchdog_mode,
    input  stage_ctl_t ctl,
    input  item_t      item,
    output result_t    result
);

    logic [DATA_W-1:0] count_reg,   count_next;
    logic [DATA_W-1:0] reload_reg,  reload_next;
    logic [CTL_W-1:0]  control_reg, control_next;
    logic              ovf_reg,     ovf_next;
    logic              ovf_en_reg,  ovf_en_next;
    logic [SYS_W-1:0]  sys_reg,     sys_next;
    logic [KEY_W-1:0]  key_reg,     key_next;
    logic              dog_reg,     dog_next;

    logic [DATA_W-1:0] rd;
    logic              wdr;
    logic              running;

    always_comb
    begin
        count_next   = count_reg;
        reload_next  = reload_reg;
        control_next = control_reg;
        ovf_next     = ovf_reg;
        ovf_en_next  = ovf_en_reg;
        sys_next     = sys_reg;
        key_next     = key_reg;
        dog_next     = dog_reg;
        rd           = '0;
        wdr          = 1'b0;
        running      = watchdog_mode ? dog_reg : control_reg[CTL_ST_BIT];

        case (item.kind)
            KIND_TICK:
            begin
                if (running)
                begin
                    if (count_reg == ALL_ONES)
                    begin
                        count_next = reload_reg;
                        ovf_next   = 1'b1;
                        if (watchdog_mode)
                        begin
                            wdr = 1'b1;
                        end
                        else if (!control_reg[CTL_AR_BIT])
                        begin
                            control_next[CTL_ST_BIT] = 1'b0;
                        end
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            KIND_READ:
            begin
                case (item.word_offset)
                    OFFS_CONFIG:  rd = {{(DATA_W-SYS_W){1'b0}}, sys_reg & CFG_STORE_MASK};
                    OFFS_RSTAT:   rd = STAT_RESETDONE;
                    OFFS_ISTAT:   rd = ovf_reg ? OVF_WORD : '0;
                    OFFS_IENABLE: rd = ovf_en_reg ? OVF_WORD : '0;
                    OFFS_CONTROL: rd = {{(DATA_W-CTL_W){1'b0}}, control_reg};
                    OFFS_COUNTER: rd = count_reg;
                    OFFS_LOAD:    rd = reload_reg;
                    default:      rd = '0;
                endcase
            end
            KIND_WRITE:
            begin
                case (item.word_offset)
                    OFFS_CONFIG:
                    begin
                        if (item.write_data[CFG_SOFTRESET_BIT])
                        begin
                            count_next   = '0;
                            reload_next  = '0;
                            control_next = '0;
                            ovf_next     = 1'b0;
                            ovf_en_next  = 1'b0;
                            key_next     = KEY_NONE;
                            dog_next     = 1'b0;
                        end
                        sys_next = item.write_data[SYS_W-1:0] & CFG_STORE_MASK;
                    end
                    OFFS_ISTAT:
                    begin
                        if (item.write_data[OVF_BIT])
                        begin
                            ovf_next = 1'b0;
                        end
                    end
                    OFFS_IENABLE: ovf_en_next  = item.write_data[OVF_BIT];
                    OFFS_CONTROL: control_next = item.write_data[CTL_W-1:0];
                    OFFS_COUNTER: count_next   = item.write_data;
                    OFFS_LOAD:    reload_next  = item.write_data;
                    OFFS_KEY:
                    begin
                        if (watchdog_mode)
                        begin
                            if (item.write_data == KEY_ON1)
                            begin
                                key_next = KEY_ON_HALF;
                            end
                            else if (item.write_data == KEY_OFF1)
                            begin
                                key_next = KEY_OFF_HALF;
                            end
                            else if (item.write_data == KEY_ON2 && key_reg == KEY_ON_HALF)
                            begin
                                dog_next = 1'b1;
                                key_next = KEY_NONE;
                            end
                            else if (item.write_data == KEY_OFF2 && key_reg == KEY_OFF_HALF)
                            begin
                                dog_next = 1'b0;
                                key_next = KEY_NONE;
                            end
                            else
                            begin
                                key_next = KEY_NONE;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            reload_reg  <= '0;
            control_reg <= '0;
            ovf_reg     <= 1'b0;
            ovf_en_reg  <= 1'b0;
            sys_reg     <= '0;
            key_reg     <= KEY_NONE;
            dog_reg     <= 1'b0;
        end
        else if (ctl.valid && ctl.advance)
        begin
            count_reg   <= count_next;
            reload_reg  <= reload_next;
            control_reg <= control_next;
            ovf_reg     <= ovf_next;
            ovf_en_reg  <= ovf_en_next;
            sys_reg     <= sys_next;
            key_reg     <= key_next;
            dog_reg     <= dog_next;
        end
    end

    assign result.read_data      = rd;
    assign result.irq            = ovf_next && ovf_en_next;
    assign result.watchdog_reset = wdr;

endmodule

// ===== hdl/twr_checker.sv =====
// Port-level checks for the timer and watchdog register block, bound to the top level.
module twr_checker import twr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [DATA_W-1:0] read_data,
    input  logic              irq,
    input  logic              watchdog_reset
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(irq)
            && $stable(watchdog_reset))
    else $error("stalled result changed");

    // a watchdog pulse comes from a tick, which reads nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && watchdog_reset |-> read_data == '0)
    else $error("watchdog pulse with read data");

    // keep the result channel empty at the first edge after reset
    assert property (@(posedge clk)
        $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind timer_watchdog_registers twr_checker u_twr_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .read_data      (read_data),
    .irq            (irq),
    .watchdog_reset (watchdog_reset)
);

// ===== tb/twr_result_checker.sv =====
// Checker for the timer and watchdog register block: predicts every result and compares it.
`timescale 1ns / 100ps

module twr_result_checker import twr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic              cfg_write_data,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [KIND_W-1:0] kind,
    input  logic [OFFS_W-1:0] word_offset,
    input  logic [DATA_W-1:0] write_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [DATA_W-1:0] read_data,
    input  logic              irq,
    input  logic              watchdog_reset,
    output int                fail_count,
    output int                expected_left,
    output int                results_checked,
    output int                bite_count,
    output int                irq_count
);

    logic              dog_mode;
    logic [DATA_W-1:0] count_now;
    logic [DATA_W-1:0] reload_now;
    logic [CTL_W-1:0]  ctl_now;
    logic              ovf_pending;
    logic              ovf_enable;
    logic [SYS_W-1:0]  sys_cfg;
    logic [KEY_W-1:0]  key_half;
    logic              dog_running;

    result_t expected_results [$];
    result_t want;
    result_t got;
    result_t fresh;

    task automatic clear_timer_state();
        count_now   = '0;
        reload_now  = '0;
        ctl_now     = '0;
        ovf_pending = 1'b0;
        ovf_enable  = 1'b0;
        key_half    = KEY_NONE;
        dog_running = 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] register_value(input logic [OFFS_W-1:0] offs);
        logic [DATA_W-1:0] value;
        value = '0;
        case (offs)
            OFFS_CONFIG:  value = {{(DATA_W-SYS_W){1'b0}}, sys_cfg & CFG_STORE_MASK};
            OFFS_RSTAT:   value = STAT_RESETDONE;
            OFFS_ISTAT:   value = ovf_pending ? OVF_WORD : '0;
            OFFS_IENABLE: value = ovf_enable ? OVF_WORD : '0;
            OFFS_CONTROL: value = {{(DATA_W-CTL_W){1'b0}}, ctl_now};
            OFFS_COUNTER: value = count_now;
            OFFS_LOAD:    value = reload_now;
            default:      value = '0;
        endcase
        return value;
    endfunction

    task automatic take_key(input logic [DATA_W-1:0] value);
        if (dog_mode)
        begin
            if (value == KEY_ON1)
                key_half = KEY_ON_HALF;
            else if (value == KEY_OFF1)
                key_half = KEY_OFF_HALF;
            else if (value == KEY_ON2 && key_half == KEY_ON_HALF)
            begin
                dog_running = 1'b1;
                key_half    = KEY_NONE;
            end
            else if (value == KEY_OFF2 && key_half == KEY_OFF_HALF)
            begin
                dog_running = 1'b0;
                key_half    = KEY_NONE;
            end
            else
                key_half = KEY_NONE;
        end
    endtask

    task automatic take_write(input logic [OFFS_W-1:0] offs, input logic [DATA_W-1:0] value);
        case (offs)
            OFFS_CONFIG:
            begin
                if (value[CFG_SOFTRESET_BIT])
                    clear_timer_state();
                sys_cfg = value[SYS_W-1:0] & CFG_STORE_MASK;
            end
            OFFS_ISTAT:
            begin
                if (value[OVF_BIT])
                    ovf_pending = 1'b0;
            end
            OFFS_IENABLE: ovf_enable = value[OVF_BIT];
            OFFS_CONTROL: ctl_now = value[CTL_W-1:0];
            OFFS_COUNTER: count_now = value;
            OFFS_LOAD:    reload_now = value;
            OFFS_KEY:     take_key(value);
            default: ;
        endcase
    endtask

    task automatic advance_timer(input item_t it, output result_t res);
        logic running;
        logic bite;
        res  = '0;
        bite = 1'b0;
        case (it.kind)
            KIND_TICK:
            begin
                running = dog_mode ? dog_running : ctl_now[CTL_ST_BIT];
                if (running)
                begin
                    if (count_now == ALL_ONES)
                    begin
                        count_now   = reload_now;
                        ovf_pending = 1'b1;
                        if (dog_mode)
                            bite = 1'b1;
                        else if (!ctl_now[CTL_AR_BIT])
                            ctl_now[CTL_ST_BIT] = 1'b0;
                    end
                    else
                        count_now = count_now + 1'b1;
                end
            end
            KIND_READ:  res.read_data = register_value(it.word_offset);
            KIND_WRITE: take_write(it.word_offset, it.write_data);
            default: ;
        endcase
        res.irq            = ovf_pending & ovf_enable;
        res.watchdog_reset = bite;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dog_mode = 1'b0;
            sys_cfg  = '0;
            clear_timer_state();
            expected_results.delete();
            fail_count      = 0;
            expected_left   = 0;
            results_checked = 0;
            bite_count      = 0;
            irq_count       = 0;
        end
        else
        begin
            if (cfg_write_en)
                dog_mode = cfg_write_data;
            if (out_valid && out_ready)
            begin
                got = {read_data, irq, watchdog_reset};
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result with nothing expected: read_data=%h irq=%b wdr=%b",
                                 got.read_data, got.irq, got.watchdog_reset);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch on result %0d: expected %h/%b/%b, got %h/%b/%b",
                                     results_checked, want.read_data, want.irq,
                                     want.watchdog_reset, got.read_data, got.irq,
                                     got.watchdog_reset);
                    end
                end
                results_checked++;
                if (got.watchdog_reset === 1'b1)
                    bite_count++;
                if (got.irq === 1'b1)
                    irq_count++;
            end
            if (in_valid && in_ready)
            begin
                advance_timer({kind, word_offset, write_data}, fresh);
                expected_results.push_back(fresh);
            end
            expected_left = expected_results.size();
        end
    end

endmodule

// ===== tb/tb_timer_watchdog_registers.sv =====
// Testbench top for the timer and watchdog register block: stimulus, handshakes and verdict.
`timescale 1ns / 100ps

module tb_timer_watchdog_registers;
    import twr_pkg::*;

    localparam logic [KIND_W-1:0] KIND_IDLE   = 2'd3;
    localparam logic [OFFS_W-1:0] OFFS_UNUSED = 5'd31;
    localparam int STALL_LIMIT    = 4000;
    localparam int ITEMS_PER_MODE = 310;
    localparam int HOLD_CYCLES    = 300;

    logic              clk;
    logic              rst_n;
    logic              cfg_write_en;
    logic              cfg_write_data;
    logic              in_valid;
    logic              in_ready;
    logic [KIND_W-1:0] kind;
    logic [OFFS_W-1:0] word_offset;
    logic [DATA_W-1:0] write_data;
    logic              out_valid;
    logic              out_ready;
    logic [DATA_W-1:0] read_data;
    logic              irq;
    logic              watchdog_reset;

    int fail_count;
    int expected_left;
    int results_checked;
    int bite_count;
    int irq_count;

    bit calm;
    int hold_len;
    int items_sent;
    int mode_writes;

    timer_watchdog_registers i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .word_offset    (word_offset),
        .write_data     (write_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_data      (read_data),
        .irq            (irq),
        .watchdog_reset (watchdog_reset)
    );

    twr_result_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .word_offset     (word_offset),
        .write_data      (write_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .read_data       (read_data),
        .irq             (irq),
        .watchdog_reset  (watchdog_reset),
        .fail_count      (fail_count),
        .expected_left   (expected_left),
        .results_checked (results_checked),
        .bite_count      (bite_count),
        .irq_count       (irq_count)
    );

    always #2 clk = ~clk;

    task automatic send_item(input logic [KIND_W-1:0] k, input logic [OFFS_W-1:0] o,
                             input logic [DATA_W-1:0] d);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            @(negedge clk) in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        kind        <= k;
        word_offset <= o;
        write_data  <= d;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic stop_items();
        @(negedge clk) in_valid <= 1'b0;
    endtask

    task automatic set_mode(input logic m);
        while (expected_left != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= m;
        @(negedge clk) cfg_write_en <= 1'b0;
        mode_writes++;
    endtask

    function automatic item_t pick_item();
        item_t it;
        int    r;
        it.kind        = KIND_TICK;
        it.word_offset = OFFS_W'($urandom);
        it.write_data  = $urandom;
        r = $urandom_range(0, 99);
        if (r < 34)
            it.kind = KIND_TICK;
        else if (r < 50)
        begin
            it.kind = KIND_READ;
            case ($urandom_range(0, 11))
                0:  it.word_offset = OFFS_CONFIG;
                1:  it.word_offset = OFFS_RSTAT;
                2:  it.word_offset = OFFS_ISTAT;
                3:  it.word_offset = OFFS_IENABLE;
                4:  it.word_offset = OFFS_CONTROL;
                5:  it.word_offset = OFFS_COUNTER;
                6:  it.word_offset = OFFS_LOAD;
                7:  it.word_offset = OFFS_PENDING;
                8:  it.word_offset = OFFS_KEY;
                9:  it.word_offset = OFFS_COUNTER;
                default: ;
            endcase
        end
        else
        begin
            it.kind = KIND_WRITE;
            if (r < 58)
            begin
                it.word_offset = OFFS_COUNTER;
                if ($urandom_range(0, 1) == 0)
                    it.write_data = ALL_ONES - $urandom_range(0, 24);
            end
            else if (r < 62)
            begin
                it.word_offset = OFFS_LOAD;
                case ($urandom_range(0, 2))
                    0: it.write_data = ALL_ONES - $urandom_range(0, 8);
                    1: it.write_data = '0;
                    default: ;
                endcase
            end
            else if (r < 68)
            begin
                it.word_offset = OFFS_CONTROL;
                if ($urandom_range(0, 2) != 0)
                    it.write_data[CTL_ST_BIT] = 1'b1;
            end
            else if (r < 71)
                it.word_offset = OFFS_IENABLE;
            else if (r < 75)
                it.word_offset = OFFS_ISTAT;
            else if (r < 83)
            begin
                it.word_offset = OFFS_KEY;
                case ($urandom_range(0, 4))
                    0: it.write_data = KEY_ON1;
                    1: it.write_data = KEY_ON2;
                    2: it.write_data = KEY_OFF1;
                    3: it.write_data = KEY_OFF2;
                    default: ;
                endcase
            end
            else if (r < 86)
            begin
                it.word_offset = OFFS_CONFIG;
                it.write_data[CFG_SOFTRESET_BIT] = ($urandom_range(0, 3) == 0);
            end
            else
                it.kind = KIND_W'($urandom);
        end
        return it;
    endfunction

    initial
    begin : result_sink
        int pause;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            pause    = (calm ? 0 : $urandom_range(0, 14)) + hold_len;
            hold_len = 0;
            if (pause > 0)
            begin
                @(negedge clk) out_ready <= 1'b0;
                repeat (pause - 1) @(negedge clk);
            end
            @(negedge clk) out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    initial
    begin : stall_watch
        int stall;
        stall = 0;
        @(posedge rst_n);
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall = 0;
            else
                stall++;
        end
        $display("no item moved for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        item_t it;
        int    r;
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = 1'b0;
        in_valid       = 1'b0;
        kind           = KIND_TICK;
        word_offset    = '0;
        write_data     = '0;
        calm           = 1'b0;
        hold_len       = 0;
        items_sent     = 0;
        mode_writes    = 0;
        repeat (11) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        set_mode(1'b0);
        send_item(KIND_READ,  OFFS_RSTAT,   '0);
        send_item(KIND_WRITE, OFFS_CONFIG,  ALL_ONES);
        send_item(KIND_READ,  OFFS_CONFIG,  '0);
        send_item(KIND_WRITE, OFFS_COUNTER, ALL_ONES);
        send_item(KIND_WRITE, OFFS_IENABLE, ALL_ONES);
        send_item(KIND_WRITE, OFFS_CONTROL, 32'd1);
        send_item(KIND_TICK,  OFFS_UNUSED,  ALL_ONES);
        send_item(KIND_TICK,  '0,           '0);
        send_item(KIND_READ,  OFFS_ISTAT,   '0);
        send_item(KIND_WRITE, OFFS_ISTAT,   OVF_WORD);
        send_item(KIND_WRITE, OFFS_KEY,     KEY_ON1);
        send_item(KIND_READ,  OFFS_PENDING, '0);
        send_item(KIND_IDLE,  OFFS_UNUSED,  ALL_ONES);
        send_item(KIND_READ,  OFFS_COUNTER, '0);
        stop_items();

        set_mode(1'b1);
        send_item(KIND_WRITE, OFFS_COUNTER, ALL_ONES);
        send_item(KIND_TICK,  '0,           '0);
        send_item(KIND_WRITE, OFFS_KEY,     KEY_ON1);
        send_item(KIND_WRITE, OFFS_KEY,     KEY_ON2);
        send_item(KIND_TICK,  '0,           '0);
        send_item(KIND_WRITE, OFFS_KEY,     KEY_OFF1);
        send_item(KIND_WRITE, OFFS_KEY,     32'h0000_1234);
        send_item(KIND_WRITE, OFFS_KEY,     KEY_OFF2);
        send_item(KIND_TICK,  '0,           '0);
        send_item(KIND_WRITE, OFFS_KEY,     KEY_OFF1);
        send_item(KIND_WRITE, OFFS_KEY,     KEY_OFF2);
        send_item(KIND_READ,  OFFS_KEY,     '0);
        stop_items();

        for (int phase = 0; phase < 4; phase++)
        begin
            set_mode(phase[0]);
            for (int n = 0; n < ITEMS_PER_MODE; n++)
            begin
                if (n % 60 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                if (phase == 2 && n == 150)
                    hold_len = HOLD_CYCLES;
                r = $urandom_range(0, 19);
                if (r < 2)
                begin
                    send_item(KIND_WRITE, OFFS_KEY, KEY_ON1);
                    send_item(KIND_WRITE, OFFS_KEY, KEY_ON2);
                end
                else if (r == 2)
                begin
                    send_item(KIND_WRITE, OFFS_KEY, KEY_OFF1);
                    send_item(KIND_WRITE, OFFS_KEY, KEY_OFF2);
                end
                else
                begin
                    it = pick_item();
                    send_item(it.kind, it.word_offset, it.write_data);
                end
            end
            stop_items();
        end

        while (expected_left != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        $display("sent %0d items over %0d mode settings, with random gaps and one long stall",
                 items_sent, mode_writes);
        $display("checked %0d results: %0d watchdog resets, %0d with irq raised",
                 results_checked, bite_count, irq_count);
        if (fail_count == 0 && expected_left == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
